FILE: hw/rtl/gtkd_pkg.sv
// shared types, codes and constants of the goertzel tone key detector
package gtkd_pkg;

  // field widths
  localparam int COEF_W     = 16;
  localparam int SAMPLE_W   = 16;
  localparam int BLEN_W     = 7;
  localparam int MANUAL_W   = 18;
  localparam int ENERGY_W   = 32;
  localparam int THR_W      = 32;
  localparam int CNT8_W     = 8;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MANUAL = 2'd3;

  // operation codes of an input transaction
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // reset values
  localparam logic signed [COEF_W-1:0] COEF_RST   = 16'sd26439;
  localparam logic [BLEN_W-1:0]        BLEN_RST   = 7'd40;
  localparam logic [MANUAL_W-1:0]      MANUAL_RST = 18'd1000;
  localparam logic [THR_W-1:0]         AVG_RST    = 32'd10000;
  localparam logic [THR_W-1:0]         THR_RST    = 32'd1000;

  // decision constants
  localparam logic [THR_W-1:0]  THR_FLOOR   = 32'd200;
  localparam logic [CNT8_W-1:0] TIMER_LIMIT = 8'd15;
  localparam logic [CNT8_W-1:0] AGREE_LIMIT = 8'd3;
  localparam logic [CNT8_W-1:0] CNT_SAT     = 8'd255;

  // fixed point layout
  localparam int STATE_FRAC = 8;
  localparam int COEF_FRAC  = 14;
  localparam int ROUND_BIAS = 8192;

  // shared multiply-accumulate unit: 24 bit chunks, up to three per operand
  localparam int CHUNK_W = 24;
  localparam int OPN_W   = 3 * CHUNK_W;
  localparam int PROD_W  = 2 * (CHUNK_W + 1);
  localparam int ACC_W   = 128;
  localparam int CIDX_W  = 2;
  localparam int SH_W    = 3;

  // energy scaling by 1000 / 2^30
  localparam int E_SAT_BIT    = 53;
  localparam int ENERGY_SHIFT = 30;
  localparam int SCALE_TOP    = ENERGY_SHIFT + ENERGY_W;
  localparam int SCALE_MUL    = 1000;

  // average step: floor(d / 1000) = floor((d + 1000 * 2^24) * recip / 2^45) - 2^24
  localparam int U_W       = 36;
  localparam int AVG_SHIFT = 45;
  localparam logic [U_W-1:0]   AVG_BIAS  = 36'd16777216000;
  localparam logic [U_W-1:0]   AVG_RECIP = 36'd35184372089;
  localparam logic [THR_W-1:0] AVG_K     = 32'h0100_0000;

  typedef struct packed {
    logic                       operation;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic                rx_key;
    logic                raw_key;
    logic [ENERGY_W-1:0] energy_level;
    logic [THR_W-1:0]    threshold;
  } out_item_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_LOAD
  } acc_op_t;

  typedef enum logic [2:0] {
    SEL_REC,
    SEL_T,
    SEL_TB,
    SEL_AA,
    SEL_BB,
    SEL_SCALE,
    SEL_AVG
  } opsel_t;

  typedef enum logic [1:0] {
    AL_ROUND,
    AL_SUM,
    AL_NEG
  } acc_sel_t;

  typedef struct packed {
    logic              start;
    logic [CIDX_W-1:0] nx;
    logic [CIDX_W-1:0] ny;
    acc_op_t           acc_op;
  } mac_cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_REC_GO,
    ST_REC_MAC,
    ST_REC_SUM,
    ST_REC_SAT,
    ST_T_GO,
    ST_T_MAC,
    ST_TB_GO,
    ST_TB_MAC,
    ST_NEG,
    ST_AA_GO,
    ST_AA_MAC,
    ST_BB_GO,
    ST_BB_MAC,
    ST_E_CHK,
    ST_SC_MAC,
    ST_SC_DONE,
    ST_DECIDE,
    ST_AVG_GO,
    ST_AVG_MAC,
    ST_AVG_DONE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic     in_ready;
    logic     start;
    opsel_t   opsel;
    acc_op_t  acc_op;
    acc_sel_t acc_sel;
    logic     rec_upd;
    logic     e_chk;
    logic     sc_done;
    logic     decide;
    logic     avg_done;
    logic     finish;
  } ctrl_t;

  typedef struct packed {
    logic in_sample;
    logic blk_end;
    logic e_direct;
    logic need_avg;
    logic out_free;
  } stat_t;

endpackage

FILE: hw/rtl/goertzel_tone_key_detector_core.sv
// top level of the goertzel tone key detector: state, decision logic and result register
//
// Input channel (in_valid / in_ready / in_data) carries one transaction per audio
// sample or timer tick. A tick only advances the transition timer. A sample runs
// the Goertzel recursion through the shared multiply-accumulate unit (one 25x25
// signed multiply a cycle over 24 bit chunks). A sample that closes a block then
// computes the energy, its scaling (skipped when the energy is out of range) and
// the key decision, updates the average on the same unit when the threshold is
// unlocked and the key has agreed long enough, and writes one result transaction.
// in_ready is high only while the sequencer is idle.
// Result channel (out_valid / out_ready / out_data) is a single output register:
// the next sample is taken while a result waits, and only the next block end holds
// off until the receiver takes the waiting result.
// Configuration (cfg_we / cfg_index / cfg_wdata) writes one register per cycle.
// Synchronous reset restores the register defaults, clears the recursion state and
// counters, sets the running average to 10000 and the threshold to 1000, and
// empties the result register.
module goertzel_tone_key_detector_core import gtkd_pkg::*; #(
  parameter int MAX_BLOCK   = 80,
  parameter int STATE_WIDTH = 40
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int A_W    = STATE_WIDTH - STATE_FRAC;
  localparam int QN     = (STATE_WIDTH + CHUNK_W - 1) / CHUNK_W;
  localparam int AN     = (A_W + CHUNK_W - 1) / CHUNK_W;
  localparam int TN     = (A_W + COEF_W + CHUNK_W - 1) / CHUNK_W;
  localparam int CNT_W  = $clog2(MAX_BLOCK);
  localparam int LEN_W  = $clog2(MAX_BLOCK + 1);
  localparam int CMP_W  = ((LEN_W > BLEN_W) ? LEN_W : BLEN_W) + 1;

  localparam logic signed [ACC_W-1:0] Q_MAX =
    {{(ACC_W-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] Q_MIN =
    {{(ACC_W-STATE_WIDTH+1){1'b1}}, {(STATE_WIDTH-1){1'b0}}};

  // configuration registers
  logic signed [COEF_W-1:0] coef_r;
  logic [BLEN_W-1:0]        blen_r;
  logic                     lock_r;
  logic [MANUAL_W-1:0]      manual_r;

  // recursion and decision state
  logic signed [STATE_WIDTH-1:0] q_prev_r, q_prev2_r, q_sat;
  logic signed [SAMPLE_W-1:0]    s_r;
  logic [CNT_W-1:0]              cnt_r;
  logic                          key_r, raw_r;
  logic [CNT8_W-1:0]             timer_r, agree_r;
  logic [THR_W-1:0]              avg_r, thr_r;
  logic [ENERGY_W-1:0]           energy_r;
  logic [U_W-1:0]                u_r;

  // result register
  logic      out_valid_r;
  out_item_t out_data_r;

  // sequencer and unit
  ctrl_t                   ctl;
  stat_t                   stat;
  mac_cmd_t                mcmd;
  logic                    mac_done;
  logic signed [OPN_W-1:0] mx, my;
  logic signed [ACC_W-1:0] acc, acc_load;

  logic signed [A_W-1:0]   a_w, b_w;
  logic [CMP_W-1:0]        blen_c, len_c, cnt_inc;
  logic                    in_acc, raw_c, flip_c;
  logic [CNT8_W-1:0]       agree_c, timer_c;
  logic [THR_W-1:0]        thr_c;

  assign in_acc = in_valid && in_ready;
  assign a_w    = q_prev_r[STATE_WIDTH-1:STATE_FRAC];
  assign b_w    = q_prev2_r[STATE_WIDTH-1:STATE_FRAC];

  // operand selection for the shared unit
  always_comb begin
    mx      = OPN_W'(q_prev_r);
    my      = OPN_W'(coef_r);
    mcmd.nx = CIDX_W'(QN);
    mcmd.ny = CIDX_W'(1);
    case (ctl.opsel)
      SEL_REC: begin
        mx      = OPN_W'(q_prev_r);
        my      = OPN_W'(coef_r);
        mcmd.nx = CIDX_W'(QN);
        mcmd.ny = CIDX_W'(1);
      end
      SEL_T: begin
        mx      = OPN_W'(a_w);
        my      = OPN_W'(coef_r);
        mcmd.nx = CIDX_W'(AN);
        mcmd.ny = CIDX_W'(1);
      end
      SEL_TB: begin
        mx      = acc[OPN_W-1:0];
        my      = OPN_W'(b_w);
        mcmd.nx = CIDX_W'(TN);
        mcmd.ny = CIDX_W'(AN);
      end
      SEL_AA: begin
        mx      = OPN_W'(a_w);
        my      = OPN_W'(a_w);
        mcmd.nx = CIDX_W'(AN);
        mcmd.ny = CIDX_W'(AN);
      end
      SEL_BB: begin
        mx      = OPN_W'(b_w);
        my      = OPN_W'(b_w);
        mcmd.nx = CIDX_W'(AN);
        mcmd.ny = CIDX_W'(AN);
      end
      SEL_SCALE: begin
        mx      = acc[OPN_W-1:0];
        my      = OPN_W'(SCALE_MUL);
        mcmd.nx = CIDX_W'(3);
        mcmd.ny = CIDX_W'(1);
      end
      SEL_AVG: begin
        mx      = {{(OPN_W-U_W){1'b0}}, u_r};
        my      = {{(OPN_W-U_W){1'b0}}, AVG_RECIP};
        mcmd.nx = CIDX_W'(2);
        mcmd.ny = CIDX_W'(2);
      end
      default: begin
        mx = '0;
        my = '0;
      end
    endcase
    mcmd.start  = ctl.start;
    mcmd.acc_op = ctl.acc_op;
  end

  // accumulator load values: rounding bias, recursion sum, negated cross term
  always_comb begin
    case (ctl.acc_sel)
      AL_ROUND: acc_load = ACC_W'(ROUND_BIAS);
      AL_SUM:   acc_load = (acc >>> COEF_FRAC) - ACC_W'(q_prev2_r)
                           + (ACC_W'(s_r) <<< STATE_FRAC);
      AL_NEG:   acc_load = -(acc >>> COEF_FRAC);
      default:  acc_load = '0;
    endcase
  end

  // recursion saturation
  always_comb begin
    if (acc > Q_MAX) begin
      q_sat = Q_MAX[STATE_WIDTH-1:0];
    end else if (acc < Q_MIN) begin
      q_sat = Q_MIN[STATE_WIDTH-1:0];
    end else begin
      q_sat = acc[STATE_WIDTH-1:0];
    end
  end

  // block length clamp and end of block
  always_comb begin
    blen_c  = CMP_W'(blen_r);
    cnt_inc = CMP_W'(cnt_r) + CMP_W'(1);
    if (blen_c == '0) begin
      len_c = CMP_W'(1);
    end else if (blen_c > CMP_W'(MAX_BLOCK)) begin
      len_c = CMP_W'(MAX_BLOCK);
    end else begin
      len_c = blen_c;
    end
  end

  // key decision for the finished block
  always_comb begin
    raw_c = energy_r > thr_r;
    if (raw_c == key_r) begin
      agree_c = (agree_r == CNT_SAT) ? agree_r : agree_r + 8'd1;
      timer_c = '0;
    end else begin
      agree_c = '0;
      timer_c = timer_r;
    end
    flip_c = timer_c > TIMER_LIMIT;
    if (lock_r) begin
      thr_c = THR_W'(manual_r);
    end else begin
      thr_c = (avg_r > THR_FLOOR) ? avg_r : THR_FLOOR;
    end
  end

  // status toward the sequencer
  always_comb begin
    stat.in_sample = in_valid && (in_data.operation == OP_SAMPLE);
    stat.blk_end   = cnt_inc >= len_c;
    stat.e_direct  = acc[ACC_W-1] || (|acc[ACC_W-2:E_SAT_BIT]);
    stat.need_avg  = (agree_c > AGREE_LIMIT) && !lock_r;
    stat.out_free  = !out_valid_r || out_ready;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r   <= COEF_RST;
      blen_r   <= BLEN_RST;
      lock_r   <= 1'b0;
      manual_r <= MANUAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COEF:   coef_r   <= cfg_wdata[COEF_W-1:0];
        CFG_BLEN:   blen_r   <= cfg_wdata[BLEN_W-1:0];
        CFG_LOCK:   lock_r   <= cfg_wdata[0];
        CFG_MANUAL: manual_r <= cfg_wdata[MANUAL_W-1:0];
        default:    lock_r   <= lock_r;
      endcase
    end
  end

  // recursion state and block counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_prev_r  <= '0;
      q_prev2_r <= '0;
      cnt_r     <= '0;
    end else if (ctl.rec_upd) begin
      q_prev2_r <= q_prev_r;
      q_prev_r  <= q_sat;
      cnt_r     <= stat.blk_end ? '0 : cnt_inc[CNT_W-1:0];
    end else if (ctl.e_chk) begin
      q_prev_r  <= '0;
      q_prev2_r <= '0;
    end
  end

  // sample capture
  always_ff @(posedge clk) begin
    if (in_acc && in_data.operation == OP_SAMPLE) begin
      s_r <= in_data.sample;
    end
  end

  // energy, average step operand
  always_ff @(posedge clk) begin
    if (ctl.e_chk && stat.e_direct) begin
      energy_r <= acc[ACC_W-1] ? '0 : '1;
    end else if (ctl.sc_done) begin
      energy_r <= (|acc[ACC_W-1:SCALE_TOP]) ? '1 : acc[SCALE_TOP-1:ENERGY_SHIFT];
    end
    if (ctl.decide) begin
      u_r <= U_W'(energy_r) - U_W'(avg_r) + AVG_BIAS;
    end
  end

  // key, timer, agreement count, average and threshold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= 1'b0;
      raw_r   <= 1'b0;
      timer_r <= '0;
      agree_r <= '0;
      avg_r   <= AVG_RST;
      thr_r   <= THR_RST;
    end else begin
      if (in_acc && in_data.operation == OP_TICK) begin
        timer_r <= (timer_r == CNT_SAT) ? timer_r : timer_r + 8'd1;
      end
      if (ctl.decide) begin
        raw_r   <= raw_c;
        agree_r <= agree_c;
        if (flip_c) begin
          key_r   <= raw_c;
          timer_r <= '0;
        end else begin
          timer_r <= timer_c;
        end
      end
      if (ctl.avg_done) begin
        avg_r <= avg_r + acc[AVG_SHIFT +: THR_W] - AVG_K;
      end
      if (ctl.finish) begin
        thr_r <= thr_c;
        if (lock_r) begin
          avg_r <= THR_W'(manual_r);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_data_r.rx_key       <= key_r;
      out_data_r.raw_key      <= raw_r;
      out_data_r.energy_level <= energy_r;
      out_data_r.threshold    <= thr_c;
    end
  end

  assign in_ready  = ctl.in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  gtkd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .done  (mac_done),
    .ctl   (ctl)
  );

  gtkd_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (mcmd),
    .x        (mx),
    .y        (my),
    .acc_load (acc_load),
    .acc      (acc),
    .done     (mac_done)
  );

  // block counter stays below the longest block
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(cnt_r) < CMP_W'(MAX_BLOCK))
    else $error("sample counter beyond block length");

  // recursion state is cleared once the block energy is taken
  a_q_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.e_chk |=> (q_prev_r == '0) && (q_prev2_r == '0))
    else $error("recursion state not cleared at block end");

  // adaptive threshold never drops below its floor
  a_thr_floor: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish && !lock_r |=> thr_r >= THR_FLOOR)
    else $error("adaptive threshold below floor");

endmodule

FILE: hw/rtl/gtkd_mac.sv
// shared chunked multiply-accumulate unit with a 25x25 signed multiplier
module gtkd_mac import gtkd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_cmd_t                cmd,
  input  logic signed [OPN_W-1:0] x,
  input  logic signed [OPN_W-1:0] y,
  input  logic signed [ACC_W-1:0] acc_load,
  output logic signed [ACC_W-1:0] acc,
  output logic                    done
);

  logic [OPN_W-1:0]         x_r, y_r;
  logic [CIDX_W-1:0]        nx_r, ny_r, i_r, j_r;
  logic                     busy_r, pv_r, last_r;
  logic signed [PROD_W-1:0] p_r;
  logic [SH_W-1:0]          sh_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [CHUNK_W:0]  ca, cb;
  logic                     i_last, j_last;

  // chunk k of an operand: the top chunk is signed, lower chunks unsigned
  function automatic logic signed [CHUNK_W:0] chunk_sel(input logic [OPN_W-1:0] v,
                                                         input logic [CIDX_W-1:0] k,
                                                         input logic [CIDX_W-1:0] n);
    logic [CHUNK_W-1:0] seg;
    logic               top_seg;
    case (k)
      2'd0:    seg = v[CHUNK_W-1:0];
      2'd1:    seg = v[2*CHUNK_W-1:CHUNK_W];
      2'd2:    seg = v[3*CHUNK_W-1:2*CHUNK_W];
      default: seg = '0;
    endcase
    top_seg = (k == n - 2'd1);
    return {top_seg & seg[CHUNK_W-1], seg};
  endfunction

  assign ca     = chunk_sel(x_r, i_r, nx_r);
  assign cb     = chunk_sel(y_r, j_r, ny_r);
  assign i_last = (i_r == nx_r - 2'd1);
  assign j_last = (j_r == ny_r - 2'd1);

  // chunk sequencing and partial product register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pv_r   <= 1'b0;
      last_r <= 1'b0;
      i_r    <= '0;
      j_r    <= '0;
    end else if (cmd.start) begin
      x_r    <= x;
      y_r    <= y;
      nx_r   <= cmd.nx;
      ny_r   <= cmd.ny;
      i_r    <= '0;
      j_r    <= '0;
      busy_r <= 1'b1;
      pv_r   <= 1'b0;
      last_r <= 1'b0;
    end else if (busy_r) begin
      p_r    <= ca * cb;
      sh_r   <= SH_W'(i_r) + SH_W'(j_r);
      pv_r   <= 1'b1;
      last_r <= i_last && j_last;
      if (j_last) begin
        j_r <= '0;
        i_r <= i_r + 2'd1;
        if (i_last) begin
          busy_r <= 1'b0;
        end
      end else begin
        j_r <= j_r + 2'd1;
      end
    end else begin
      pv_r   <= 1'b0;
      last_r <= 1'b0;
    end
  end

  // accumulator: shifted partial products, or a clear or load between runs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + (ACC_W'(p_r) <<< (sh_r * CHUNK_W));
    end else begin
      case (cmd.acc_op)
        ACC_CLEAR: acc_r <= '0;
        ACC_LOAD:  acc_r <= acc_load;
        default:   acc_r <= acc_r;
      endcase
    end
  end

  assign acc  = acc_r;
  assign done = pv_r && last_r;

  // a run is only started on an idle unit
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !busy_r && !pv_r)
    else $error("multiply run started while unit busy");

  // clear or load never collides with an accumulation
  a_acc_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.acc_op != ACC_HOLD) |-> !busy_r && !pv_r)
    else $error("accumulator overwritten during a run");

  // every issued chunk pair yields a product in the next cycle
  a_issue_prod: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !cmd.start |=> pv_r)
    else $error("issued chunk pair lost its product");

endmodule

FILE: hw/rtl/gtkd_ctrl.sv
// sequencer that steps the shared multiply-accumulate unit through each sample transaction
module gtkd_ctrl import gtkd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  input  logic  done,
  output ctrl_t ctl
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (stat.in_sample) state_nxt = ST_REC_GO;
      ST_REC_GO:   state_nxt = ST_REC_MAC;
      ST_REC_MAC:  if (done) state_nxt = ST_REC_SUM;
      ST_REC_SUM:  state_nxt = ST_REC_SAT;
      ST_REC_SAT:  state_nxt = stat.blk_end ? ST_T_GO : ST_IDLE;
      ST_T_GO:     state_nxt = ST_T_MAC;
      ST_T_MAC:    if (done) state_nxt = ST_TB_GO;
      ST_TB_GO:    state_nxt = ST_TB_MAC;
      ST_TB_MAC:   if (done) state_nxt = ST_NEG;
      ST_NEG:      state_nxt = ST_AA_GO;
      ST_AA_GO:    state_nxt = ST_AA_MAC;
      ST_AA_MAC:   if (done) state_nxt = ST_BB_GO;
      ST_BB_GO:    state_nxt = ST_BB_MAC;
      ST_BB_MAC:   if (done) state_nxt = ST_E_CHK;
      ST_E_CHK:    state_nxt = stat.e_direct ? ST_DECIDE : ST_SC_MAC;
      ST_SC_MAC:   if (done) state_nxt = ST_SC_DONE;
      ST_SC_DONE:  state_nxt = ST_DECIDE;
      ST_DECIDE:   state_nxt = stat.need_avg ? ST_AVG_GO : ST_FINISH;
      ST_AVG_GO:   state_nxt = ST_AVG_MAC;
      ST_AVG_MAC:  if (done) state_nxt = ST_AVG_DONE;
      ST_AVG_DONE: state_nxt = ST_FINISH;
      ST_FINISH:   if (stat.out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // per-state controls
  always_comb begin
    ctl          = '0;
    ctl.opsel    = SEL_REC;
    ctl.acc_op   = ACC_HOLD;
    ctl.acc_sel  = AL_ROUND;
    case (state_r)
      ST_IDLE: begin
        ctl.in_ready = 1'b1;
      end
      ST_REC_GO: begin
        ctl.start   = 1'b1;
        ctl.opsel   = SEL_REC;
        ctl.acc_op  = ACC_LOAD;
        ctl.acc_sel = AL_ROUND;
      end
      ST_REC_SUM: begin
        ctl.acc_op  = ACC_LOAD;
        ctl.acc_sel = AL_SUM;
      end
      ST_REC_SAT: begin
        ctl.rec_upd = 1'b1;
      end
      ST_T_GO: begin
        ctl.start  = 1'b1;
        ctl.opsel  = SEL_T;
        ctl.acc_op = ACC_CLEAR;
      end
      ST_TB_GO: begin
        ctl.start  = 1'b1;
        ctl.opsel  = SEL_TB;
        ctl.acc_op = ACC_CLEAR;
      end
      ST_NEG: begin
        ctl.acc_op  = ACC_LOAD;
        ctl.acc_sel = AL_NEG;
      end
      ST_AA_GO: begin
        ctl.start = 1'b1;
        ctl.opsel = SEL_AA;
      end
      ST_BB_GO: begin
        ctl.start = 1'b1;
        ctl.opsel = SEL_BB;
      end
      ST_E_CHK: begin
        ctl.e_chk = 1'b1;
        if (!stat.e_direct) begin
          ctl.start  = 1'b1;
          ctl.opsel  = SEL_SCALE;
          ctl.acc_op = ACC_CLEAR;
        end
      end
      ST_SC_DONE: begin
        ctl.sc_done = 1'b1;
      end
      ST_DECIDE: begin
        ctl.decide = 1'b1;
      end
      ST_AVG_GO: begin
        ctl.start  = 1'b1;
        ctl.opsel  = SEL_AVG;
        ctl.acc_op = ACC_CLEAR;
      end
      ST_AVG_DONE: begin
        ctl.avg_done = 1'b1;
      end
      ST_FINISH: begin
        ctl.finish = stat.out_free;
      end
      default: begin
        ctl.in_ready = 1'b0;
      end
    endcase
  end

endmodule
